[hdl/mpid_pkg.sv]
// shared types and constants for the multichannel pid motor controller
// no dependencies; imported by the controller top level and the checker

package mpid_pkg;

    // field widths fixed by the sample and drive formats
    localparam int CH_W     = 2;
    localparam int POS_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int WIN_W    = 16;
    localparam int LIM_W    = 7;
    localparam int DRIVE_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // derived datapath widths
    localparam int ERR_W    = POS_W + 1;        // measured - setpoint
    localparam int DIFF_W   = ERR_W + 1;        // error - previous error
    localparam int INTEG_W  = 24;               // saturating integral
    localparam int PP_W     = GAIN_W + ERR_W;
    localparam int PI_W     = GAIN_W + INTEG_W;
    localparam int PD_W     = GAIN_W + DIFF_W;
    localparam int SUM_W    = PI_W + 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_ENABLE      = 3'd0,
        CFG_KP              = 3'd1,
        CFG_KI              = 3'd2,
        CFG_KD              = 3'd3,
        CFG_INTEGRAL_WINDOW = 3'd4,
        CFG_DRIVE_LIMIT     = 3'd5,
        CFG_INVERT_OUTPUT   = 3'd6
    } t_cfg_idx;

    // configuration reset values
    localparam logic              RST_RUN_ENABLE = 1'b1;
    localparam logic [GAIN_W-1:0] RST_KP         = 16'd512;
    localparam logic [GAIN_W-1:0] RST_KI         = 16'd10;
    localparam logic [GAIN_W-1:0] RST_KD         = 16'd0;
    localparam logic [WIN_W-1:0]  RST_WINDOW     = 16'd50;
    localparam logic [LIM_W-1:0]  RST_LIMIT      = 7'd127;
    localparam logic              RST_INVERT     = 1'b1;

    // integral saturation bounds
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 24'sh7FFFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 24'sh800000;

    // per-channel state entry held in memory
    typedef struct packed {
        logic signed [INTEG_W-1:0] integ;
        logic signed [ERR_W-1:0]   prev_err;
    } t_chan_state;

    localparam int STATE_W = $bits(t_chan_state);

endpackage

[hdl/mpid_ram.sv]
// generic single-write, single-read synchronous ram with registered read
// no dependencies; holds the per-channel controller state

module mpid_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/multichannel_pid_motor_controller_top.sv]
// multichannel pid position controller with integral window, top level
// depends on mpid_pkg and mpid_ram (per-channel integral and last error)
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  ----------------------------------
//  sample   in         i_in_valid / o_in_stall    i_channel, i_measured, i_setpoint
//  drive    out        o_out_valid / i_out_stall  o_out_channel, o_drive, o_clamped
//  config   in         i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// one sample per cycle while no drive is held. the state ram read is issued at
// the accepting edge, which loads stage a; read-modify-write with forwarding,
// gain multiplies and sum / shift / clamp load stages b, c and the drive register.
// synchronous reset restores register defaults and marks all channel state
// as zero through per-entry valid bits; no clearing pass is needed.
// a stalled output holds the whole pipeline; o_in_stall follows it directly.

module multichannel_pid_motor_controller_top
    import mpid_pkg::*;
#(
    parameter int NUM_CHANNELS   = 4,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CH_W-1:0]          i_channel,
    input  logic signed [POS_W-1:0]  i_measured,
    input  logic signed [POS_W-1:0]  i_setpoint,
    // drive channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CH_W-1:0]          o_out_channel,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic                     o_clamped,
    // configuration
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // configuration registers
    logic                     r_run_enable;
    logic signed [GAIN_W-1:0] r_kp;
    logic signed [GAIN_W-1:0] r_ki;
    logic signed [GAIN_W-1:0] r_kd;
    logic [WIN_W-1:0]         r_window;
    logic [LIM_W-1:0]         r_limit;
    logic                     r_invert;

    // config write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable <= RST_RUN_ENABLE;
            r_kp         <= RST_KP;
            r_ki         <= RST_KI;
            r_kd         <= RST_KD;
            r_window     <= RST_WINDOW;
            r_limit      <= RST_LIMIT;
            r_invert     <= RST_INVERT;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RUN_ENABLE:      r_run_enable <= i_cfg_data[0];
                CFG_KP:              r_kp         <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:              r_ki         <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:              r_kd         <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_WINDOW: r_window     <= i_cfg_data[WIN_W-1:0];
                CFG_DRIVE_LIMIT:     r_limit      <= i_cfg_data[LIM_W-1:0];
                CFG_INVERT_OUTPUT:   r_invert     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline advance: everything moves unless a finished drive is held
    logic r_out_valid;
    logic pipe_en;
    logic in_accept;

    assign pipe_en    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !pipe_en;
    assign in_accept  = i_in_valid && pipe_en;

    // stage a: sample registered, state read in flight
    logic                    r_a_valid;
    logic [CH_W-1:0]         r_a_ch;
    logic [AW-1:0]           r_a_addr;
    logic                    r_a_in_range;
    logic                    r_a_entry_vld;
    logic signed [ERR_W-1:0] r_a_err;

    logic [AW-1:0]           in_addr;
    logic                    in_range;
    logic signed [ERR_W-1:0] in_err;
    logic [NUM_CHANNELS-1:0] r_entry_vld;

    assign in_addr  = AW'(i_channel);
    assign in_range = (32'(i_channel) < 32'(NUM_CHANNELS));
    assign in_err   = ERR_W'(i_measured) - ERR_W'(i_setpoint);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (pipe_en) begin
            r_a_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_a_ch        <= i_channel;
            r_a_addr      <= in_addr;
            r_a_in_range  <= in_range;
            r_a_entry_vld <= in_range ? r_entry_vld[in_addr] : 1'b0;
            r_a_err       <= in_err;
        end
    end

    // channel state memory
    logic        st_wr_en;
    t_chan_state st_wr_data;
    t_chan_state st_rd_data;

    mpid_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_CHANNELS),
        .ADDR_W(AW)
    ) u_state_ram (
        .i_clk    (i_clk),
        .i_wr_en  (st_wr_en),
        .i_wr_addr(r_a_addr),
        .i_wr_data(st_wr_data),
        .i_rd_en  (pipe_en),
        .i_rd_addr(in_addr),
        .o_rd_data(st_rd_data)
    );

    // last write, forwarded to the item that read the same entry alongside it
    logic        r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_chan_state r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (pipe_en) begin
            r_fwd_valid <= st_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_wr_en) begin
            r_fwd_addr <= r_a_addr;
            r_fwd_data <= st_wr_data;
        end
    end

    // entry valid bits: an unwritten channel reads as zero state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
        end else if (st_wr_en) begin
            r_entry_vld[r_a_addr] <= 1'b1;
        end
    end

    // read-modify-write of the channel state
    t_chan_state              cur_state;
    logic [ERR_W-1:0]         err_mag;
    logic                     integ_on;
    logic signed [INTEG_W:0]  integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [INTEG_W-1:0] n_integ;
    logic signed [DIFF_W-1:0] n_diff;
    t_chan_state              new_state;

    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_a_addr)) begin
            cur_state = r_fwd_data;
        end else if (r_a_entry_vld) begin
            cur_state = st_rd_data;
        end else begin
            cur_state = '0;
        end

        err_mag   = r_a_err[ERR_W-1] ? ERR_W'(-r_a_err) : ERR_W'(r_a_err);
        integ_on  = (r_ki != '0) && (err_mag < ERR_W'(r_window));
        integ_sum = (INTEG_W+1)'(cur_state.integ) + (INTEG_W+1)'(r_a_err);

        // saturate when the carry and sign bits disagree
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end

        n_integ = integ_on ? integ_sat : '0;
        n_diff  = DIFF_W'(r_a_err) - DIFF_W'(cur_state.prev_err);

        new_state.integ    = n_integ;
        new_state.prev_err = r_a_err;
    end

    // while run is disabled the state is written as zero; out-of-range samples write nothing
    assign st_wr_en   = pipe_en && r_a_valid && r_a_in_range;
    assign st_wr_data = r_run_enable ? new_state : '0;

    // stage b: updated terms
    logic                      r_b_valid;
    logic [CH_W-1:0]           r_b_ch;
    logic                      r_b_active;
    logic signed [ERR_W-1:0]   r_b_err;
    logic signed [INTEG_W-1:0] r_b_integ;
    logic signed [DIFF_W-1:0]  r_b_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (pipe_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_b_ch     <= r_a_ch;
            r_b_active <= r_a_in_range && r_run_enable;
            r_b_err    <= r_a_err;
            r_b_integ  <= n_integ;
            r_b_diff   <= n_diff;
        end
    end

    // stage c: the three gain products
    logic                   r_c_valid;
    logic [CH_W-1:0]        r_c_ch;
    logic                   r_c_active;
    logic signed [PP_W-1:0] r_c_pp;
    logic signed [PI_W-1:0] r_c_pi;
    logic signed [PD_W-1:0] r_c_pd;

    logic signed [PP_W-1:0] n_pp;
    logic signed [PI_W-1:0] n_pi;
    logic signed [PD_W-1:0] n_pd;

    assign n_pp = r_kp * r_b_err;
    assign n_pi = r_ki * r_b_integ;
    assign n_pd = r_kd * r_b_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (pipe_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_c_ch     <= r_b_ch;
            r_c_active <= r_b_active;
            r_c_pp     <= n_pp;
            r_c_pi     <= n_pi;
            r_c_pd     <= n_pd;
        end
    end

    // sum, floor shift, clamp and optional inversion
    logic signed [SUM_W-1:0]   pid_sum;
    logic signed [SUM_W-1:0]   pid_q;
    logic signed [SUM_W-1:0]   lim_pos;
    logic signed [SUM_W-1:0]   lim_neg;
    logic signed [DRIVE_W-1:0] clip_drv;
    logic                      clip_hit;
    logic signed [DRIVE_W-1:0] n_drive;
    logic                      n_clamped;

    always_comb begin
        pid_sum = SUM_W'(r_c_pp) + SUM_W'(r_c_pi) + SUM_W'(r_c_pd);
        pid_q   = pid_sum >>> GAIN_FRAC_BITS;
        lim_pos = SUM_W'(r_limit);
        lim_neg = -lim_pos;

        if (pid_q > lim_pos) begin
            clip_drv = DRIVE_W'(lim_pos);
            clip_hit = 1'b1;
        end else if (pid_q < lim_neg) begin
            clip_drv = DRIVE_W'(lim_neg);
            clip_hit = 1'b1;
        end else begin
            clip_drv = pid_q[DRIVE_W-1:0];
            clip_hit = 1'b0;
        end

        if (!r_c_active) begin
            n_drive   = '0;
            n_clamped = 1'b0;
        end else begin
            n_drive   = r_invert ? DRIVE_W'(-clip_drv) : clip_drv;
            n_clamped = clip_hit;
        end
    end

    // output register
    logic [CH_W-1:0]           r_out_ch;
    logic signed [DRIVE_W-1:0] r_out_drive;
    logic                      r_out_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out_ch      <= r_c_ch;
            r_out_drive   <= n_drive;
            r_out_clamped <= n_clamped;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_drive       = r_out_drive;
    assign o_clamped     = r_out_clamped;

endmodule

[hdl/mpid_checker.sv]
// port-level assertions for the multichannel pid motor controller
// depends on mpid_pkg; bound to multichannel_pid_motor_controller_top below

module mpid_checker
    import mpid_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [CH_W-1:0]           o_out_channel,
    input logic signed [DRIVE_W-1:0] o_drive,
    input logic                      o_clamped
);

    // a held drive transaction keeps its valid
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("drive valid dropped while stalled");

    // a held drive transaction keeps its payload
    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_out_channel) && $stable(o_drive) && $stable(o_clamped)))
        else $error("drive payload changed while stalled");

    // the sample side only stalls behind a held drive transaction
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("sample stalled without a held drive");

    // an accepted sample reaches the output if the drive side does not stall meanwhile
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall ##1 !i_out_stall
            ##1 !i_out_stall |=> o_out_valid)
        else $error("drive transaction missing after pipeline latency");

    // clamped drive never reaches the most negative code
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive != 8'sh80))
        else $error("drive outside the symmetric range");

endmodule

bind multichannel_pid_motor_controller_top mpid_checker u_mpid_checker (.*);
